// ===== design/pfw_pkg.sv =====
package pfw_pkg;

    localparam int WORD_CAPACITY_DEF = 60;
    localparam logic [7:0] FILL_COLUMN_RST = 8'd72;

    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_DOT   = 8'd46;

    typedef struct packed {
        logic [7:0] in_char;
        logic       first_of_paragraph;
        logic [7:0] start_column;
        logic       last_of_paragraph;
        logic       append_newline;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       fill_error;
        logic       run_end;
    } out_item_t;

    // emit command from front to back; word length travels beside it
    typedef struct packed {
        logic       err;
        logic       has_word;
        logic       nl_first;
        logic [1:0] gap;
        logic       close_nl;
    } cmd_t;

endpackage

// ===== design/pfw_queue.sv =====
module pfw_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== design/pfw_front.sv =====
module pfw_front #(
    parameter int WORD_CAPACITY = pfw_pkg::WORD_CAPACITY_DEF,
    parameter int LEN_W         = 6,
    parameter int ADDR_W        = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  pfw_pkg::in_item_t  s_data,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output pfw_pkg::cmd_t      cmd,
    output logic [LEN_W-1:0]   cmd_len,
    output logic               mem_we,
    output logic [ADDR_W-1:0]  mem_addr,
    output logic [7:0]         mem_wdata,
    output logic               word_pend,
    input  logic               word_done
);

    typedef enum logic [1:0] {
        SEP_NONE  = 2'd0,
        SEP_SPACE = 2'd1,
        SEP_NL    = 2'd2
    } sep_kind_t;

    logic [7:0]       fill_col_reg;
    logic [LEN_W-1:0] word_len_reg;
    logic [LEN_W-1:0] word_len_next;
    logic [15:0]      line_col_reg;
    logic [15:0]      line_col_next;
    logic             prev_dot_reg;
    logic             prev_dot_next;
    logic             cur_dot_reg;
    logic             cur_dot_next;
    sep_kind_t        sep_reg;
    sep_kind_t        sep_next;
    logic             pend_reg;

    logic [7:0]       ch;
    logic             is_sep;
    logic             is_char;
    logic             err;
    logic [15:0]      lc_e;
    logic [LEN_W-1:0] wl_e;
    logic             pd_e;
    logic             cd_e;
    sep_kind_t        sep_e;
    logic             room;
    logic [LEN_W-1:0] wl_a;
    logic             emit;
    logic             close_nl;
    logic [1:0]       gap;
    logic [16:0]      sum;
    logic             fits;
    logic             accept;

    assign ch      = s_data.in_char;
    assign is_sep  = (ch == pfw_pkg::CHAR_SPACE) || (ch == pfw_pkg::CHAR_TAB) ||
                     (ch == pfw_pkg::CHAR_NL);
    assign is_char = !is_sep;
    assign err     = (fill_col_reg == 8'd0);

    // first item of a paragraph starts from a clean slate
    assign lc_e  = s_data.first_of_paragraph ? {8'd0, s_data.start_column} : line_col_reg;
    assign wl_e  = s_data.first_of_paragraph ? '0 : word_len_reg;
    assign pd_e  = s_data.first_of_paragraph ? 1'b0 : prev_dot_reg;
    assign cd_e  = s_data.first_of_paragraph ? 1'b0 : cur_dot_reg;
    assign sep_e = s_data.first_of_paragraph ? SEP_NONE : sep_reg;

    assign room     = (wl_e < LEN_W'(WORD_CAPACITY));
    assign wl_a     = (is_char && room) ? wl_e + LEN_W'(1) : wl_e;
    assign emit     = (wl_a != '0) && (is_sep || s_data.last_of_paragraph);
    assign close_nl = s_data.last_of_paragraph && s_data.append_newline;
    assign gap      = {1'b0, pd_e} + {1'b0, sep_e != SEP_NONE};
    assign sum      = {1'b0, lc_e} + 17'(gap) + 17'(wl_a);
    assign fits     = (sum <= 17'(fill_col_reg));

    // a new character may not overwrite the store while a word is read out
    assign s_ready = cmd_ready && !(pend_reg && !err && is_char);
    assign accept  = s_valid && s_ready;

    assign cmd_valid     = accept && (err || emit || close_nl);
    assign cmd.err       = err;
    assign cmd.has_word  = !err && emit;
    assign cmd.nl_first  = !fits;
    assign cmd.gap       = gap;
    assign cmd.close_nl  = !err && close_nl;
    assign cmd_len       = wl_a;

    assign mem_we    = accept && !err && is_char && room;
    assign mem_addr  = wl_e[ADDR_W-1:0];
    assign mem_wdata = ch;
    assign word_pend = pend_reg;

    always_comb begin
        word_len_next = emit ? '0 : wl_a;
        line_col_next = emit ? (fits ? sum[15:0] : 16'(wl_a)) : lc_e;
        cur_dot_next  = is_char ? (ch == pfw_pkg::CHAR_DOT) : cd_e;
        prev_dot_next = emit ? cur_dot_next : pd_e;
        if (is_sep) begin
            if (emit || sep_e != SEP_NONE || ch != pfw_pkg::CHAR_NL) begin
                sep_next = SEP_SPACE;
            end else begin
                sep_next = SEP_NL;
            end
        end else begin
            sep_next = emit ? SEP_SPACE : sep_e;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_col_reg <= pfw_pkg::FILL_COLUMN_RST;
            word_len_reg <= '0;
            line_col_reg <= 16'd0;
            prev_dot_reg <= 1'b0;
            cur_dot_reg  <= 1'b0;
            sep_reg      <= SEP_NONE;
            pend_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                fill_col_reg <= cfg_wr_data;
            end
            if (accept && !err) begin
                word_len_reg <= word_len_next;
                line_col_reg <= line_col_next;
                prev_dot_reg <= prev_dot_next;
                cur_dot_reg  <= cur_dot_next;
                sep_reg      <= sep_next;
            end
            if (accept && !err && emit) begin
                pend_reg <= 1'b1;
            end else if (word_done) begin
                pend_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/pfw_back.sv =====
module pfw_back #(
    parameter int WORD_CAPACITY = pfw_pkg::WORD_CAPACITY_DEF,
    parameter int LEN_W         = 6,
    parameter int ADDR_W        = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               mem_we,
    input  logic [ADDR_W-1:0]  mem_addr,
    input  logic [7:0]         mem_wdata,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  pfw_pkg::cmd_t      cmd,
    input  logic [LEN_W-1:0]   cmd_len,
    output logic               word_done,
    output logic               m_valid,
    input  logic               m_ready,
    output pfw_pkg::out_item_t m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_LOAD,
        ST_PRE,
        ST_WORD,
        ST_CLOSE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    pfw_pkg::cmd_t      cmd_reg;
    pfw_pkg::cmd_t      cmd_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic [LEN_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   idx_next;
    logic [1:0]         pre_cnt_reg;
    logic [1:0]         pre_cnt_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    pfw_pkg::out_item_t m_data_reg;
    pfw_pkg::out_item_t m_data_next;

    logic [7:0]         word_mem [WORD_CAPACITY];
    logic [7:0]         rdata_reg;
    logic [LEN_W-1:0]   rd_idx;
    logic               slot_free;
    logic               last_chr;

    assign slot_free = !m_valid_reg || m_ready;
    assign last_chr  = (idx_reg == len_reg - LEN_W'(1));
    assign rd_idx    = (state_reg == ST_WORD && slot_free) ? idx_reg + LEN_W'(1) : idx_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        pre_cnt_next = pre_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        cmd_ready    = 1'b0;
        word_done    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next     = cmd;
                    len_next     = cmd_len;
                    idx_next     = '0;
                    pre_cnt_next = cmd.nl_first ? 2'd1 : cmd.gap;
                    if (cmd.err) begin
                        state_next = ST_ERR;
                    end else if (cmd.has_word) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: 8'd0, fill_error: 1'b1, run_end: 1'b1};
                    state_next   = ST_IDLE;
                end
            end
            ST_LOAD: begin
                state_next = (pre_cnt_reg != 2'd0) ? ST_PRE : ST_WORD;
            end
            ST_PRE: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: cmd_reg.nl_first ? pfw_pkg::CHAR_NL :
                                               pfw_pkg::CHAR_SPACE,
                                     fill_error: 1'b0, run_end: 1'b0};
                    pre_cnt_next = pre_cnt_reg - 2'd1;
                    if (pre_cnt_reg == 2'd1) begin
                        state_next = ST_WORD;
                    end
                end
            end
            ST_WORD: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: rdata_reg, fill_error: 1'b0,
                                     run_end: last_chr && !cmd_reg.close_nl};
                    idx_next     = idx_reg + LEN_W'(1);
                    if (last_chr) begin
                        word_done  = 1'b1;
                        state_next = cmd_reg.close_nl ? ST_CLOSE : ST_IDLE;
                    end
                end
            end
            ST_CLOSE: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: pfw_pkg::CHAR_NL, fill_error: 1'b0,
                                     run_end: 1'b1};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            pre_cnt_reg <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pre_cnt_reg <= pre_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        len_reg    <= len_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            word_mem[mem_addr] <= mem_wdata;
        end
        if (rd_idx < LEN_W'(WORD_CAPACITY)) begin
            rdata_reg <= word_mem[rd_idx[ADDR_W-1:0]];
        end
    end

endmodule

// ===== design/paragraph_fill_wrapper_top.sv =====
// Path to the first result: the back end takes the command; when a word is emitted,
// the word store is read; then the result enters the output register.
// Throughput: one result per cycle while emitting and m_ready is high. Input: one
// item per cycle while the command queue has room; a word character waits while the
// previous word is still read out of the store.
// Reset: aresetn, synchronous, active low; clears control, fill column 72, store kept.
module paragraph_fill_wrapper_top #(
    parameter int WORD_CAPACITY = pfw_pkg::WORD_CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  pfw_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pfw_pkg::out_item_t m_data
);

    localparam int LEN_W  = $clog2(WORD_CAPACITY + 1);
    localparam int ADDR_W = (WORD_CAPACITY > 1) ? $clog2(WORD_CAPACITY) : 1;
    localparam int CMD_W  = $bits(pfw_pkg::cmd_t);
    localparam int Q_W    = CMD_W + LEN_W;

    logic               f_cmd_valid;
    logic               f_cmd_ready;
    pfw_pkg::cmd_t      f_cmd;
    logic [LEN_W-1:0]   f_cmd_len;
    logic               b_cmd_valid;
    logic               b_cmd_ready;
    logic [Q_W-1:0]     q_out;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [7:0]         mem_wdata;
    logic               word_pend;
    logic               word_done;

    pfw_front #(
        .WORD_CAPACITY(WORD_CAPACITY),
        .LEN_W        (LEN_W),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cmd_valid  (f_cmd_valid),
        .cmd_ready  (f_cmd_ready),
        .cmd        (f_cmd),
        .cmd_len    (f_cmd_len),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .word_pend  (word_pend),
        .word_done  (word_done)
    );

    pfw_queue #(
        .DATA_W(Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_cmd_valid),
        .in_ready (f_cmd_ready),
        .in_data  ({f_cmd, f_cmd_len}),
        .out_valid(b_cmd_valid),
        .out_ready(b_cmd_ready),
        .out_data (q_out)
    );

    pfw_back #(
        .WORD_CAPACITY(WORD_CAPACITY),
        .LEN_W        (LEN_W),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mem_we   (mem_we),
        .mem_addr (mem_addr),
        .mem_wdata(mem_wdata),
        .cmd_valid(b_cmd_valid),
        .cmd_ready(b_cmd_ready),
        .cmd      (pfw_pkg::cmd_t'(q_out[Q_W-1:LEN_W])),
        .cmd_len  (q_out[LEN_W-1:0]),
        .word_done(word_done),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_no_write_during_readout: assert property (
        @(posedge aclk) disable iff (!aresetn) mem_we |-> !word_pend
    ) else $error("word store written while a word is read out");

    a_done_only_when_pending: assert property (
        @(posedge aclk) disable iff (!aresetn) word_done |-> word_pend
    ) else $error("word readout finished without a pending word");

    a_error_result_shape: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.fill_error) |-> (m_data.run_end && m_data.out_char == 8'd0)
    ) else $error("error result malformed");

endmodule
